// ----- rtl/asa_pkg.sv -----
package asa_pkg;

    localparam int ASA_MAX_ROWS = 64;

    // Register indexes of the configuration port.
    localparam logic CFG_INITIAL_SIDE = 1'b0;
    localparam logic CFG_MAX_SIDE     = 1'b1;

    localparam logic [16:0] RESET_SIDE     = 17'd256;
    localparam logic [16:0] RESET_MAX_SIDE = 17'd4096;
    localparam logic [17:0] SIDE_LIMIT     = 18'd65536;

    typedef struct packed {
        logic [9:0] rect_width;
        logic [9:0] rect_height;
    } req_t;

    typedef struct packed {
        logic [15:0] pos_x;
        logic [15:0] pos_y;
        logic        granted;
        logic [16:0] atlas_side;
        logic        opened_row;
    } rsp_t;

    // Request fields seen by every cell during a search.
    typedef struct packed {
        logic [9:0]  w;
        logic [9:0]  h;
        logic [16:0] side;
    } bcast_t;

    // Best row found so far, handed from cell to cell.
    typedef struct packed {
        logic        valid;
        logic        found;
        logic [10:0] size;
        logic [16:0] fill;
        logic [15:0] offset;
    } chain_t;

    // Row update: either open a new row or add a width to a row's fill.
    typedef struct packed {
        logic        en;
        logic        open;
        logic [15:0] offset;
        logic [10:0] size;
        logic [9:0]  w;
    } wr_t;

    function automatic logic [16:0] limit_side(input logic [16:0] s);
        logic [16:0] r;
        if (s == 17'd0)
        begin
            r = 17'd1;
        end
        else if ({1'b0, s} > SIDE_LIMIT)
        begin
            r = SIDE_LIMIT[16:0];
        end
        else
        begin
            r = s;
        end
        return r;
    endfunction

    // Row height for a new shelf: h + h/10 + 1. The reciprocal product is
    // exact for every ten-bit height.
    function automatic logic [10:0] new_row_height(input logic [9:0] h);
        logic [17:0] prod;
        prod = 18'(h) * 18'd205;
        return 11'(h) + 11'(prod[17:11]) + 11'd1;
    endfunction

endpackage

// ----- rtl/asa_cell.sv -----
module asa_cell
    import asa_pkg::*;
#(
    parameter int MAX_ROWS = ASA_MAX_ROWS,
    parameter int IDX      = 0,
    localparam int CW      = $clog2(MAX_ROWS + 1),
    localparam int IW      = $clog2(MAX_ROWS)
)
(
    input  logic          clk,
    input  logic          rst_n,
    input  bcast_t        bcast,
    input  logic [CW-1:0] row_count,
    input  wr_t           wr,
    input  logic [IW-1:0] wr_idx,
    input  chain_t        chain_in,
    input  logic [IW-1:0] idx_in,
    output chain_t        chain_out,
    output logic [IW-1:0] idx_out
);

    logic [15:0]   offset_reg;
    logic [16:0]   fill_reg;
    logic [10:0]   size_reg;
    logic [16:0]   fill_next;
    chain_t        chain_reg;
    chain_t        chain_next;
    logic [IW-1:0] idx_reg;
    logic [IW-1:0] idx_next;
    logic          active;
    logic          fit;
    logic          take;
    logic          sel;
    logic [13:0]   h_times_10;
    logic [13:0]   size_times_7;

    assign active       = CW'(IDX) < row_count;
    assign h_times_10   = 14'(bcast.h) * 14'd10;
    assign size_times_7 = 14'(size_reg) * 14'd7;
    assign sel          = wr.en && (wr_idx == IW'(IDX));

    always_comb
    begin
        fit = active && ({1'b0, bcast.h} <= size_reg) && (h_times_10 >= size_times_7)
              && (fill_reg <= bcast.side)
              && ((bcast.side - fill_reg) >= 17'(bcast.w));
        take = fit && (!chain_in.found || (size_reg < chain_in.size));

        chain_next       = chain_in;
        idx_next         = idx_in;
        chain_next.found = chain_in.found || fit;
        if (take)
        begin
            chain_next.size   = size_reg;
            chain_next.fill   = fill_reg;
            chain_next.offset = offset_reg;
            idx_next          = IW'(IDX);
        end

        if (wr.open)
        begin
            fill_next = 17'(wr.w);
        end
        else
        begin
            fill_next = fill_reg + 17'(wr.w);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            chain_reg <= '0;
        end
        else
        begin
            chain_reg <= chain_next;
        end
    end

    always_ff @(posedge clk)
    begin
        idx_reg <= idx_next;
        if (sel)
        begin
            fill_reg <= fill_next;
            if (wr.open)
            begin
                offset_reg <= wr.offset;
                size_reg   <= wr.size;
            end
        end
    end

    assign chain_out = chain_reg;
    assign idx_out   = idx_reg;

endmodule

// ----- rtl/atlas_shelf_allocator.sv -----
// Shelf allocator for a square texture atlas. Each request transaction asks for a
// rectangle and gets one response transaction with its position, or a refusal.
// The rows live in a chain of MAX_ROWS cells; a search token walks the chain one
// cell per cycle. A request that fits an existing row is answered once the token
// has left the chain. For a request that opens a new row, the atlas side is first
// doubled as often as the row needs; the request is refused when the row table is
// full or a doubling would pass the maximum side or the side limit. A request wider
// than the atlas is refused without a search. A response waits while the previous
// one is stalled. One request is worked on at a time; a new one may be accepted
// while the previous response is still waiting to be taken. The user must make
// configuration writes only while the block is idle; the block does not enforce
// this. A write of initial_side changes the current side only while no row exists.
module atlas_shelf_allocator
    import asa_pkg::*;
#(
    parameter int MAX_ROWS = ASA_MAX_ROWS
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        req_valid,
    output logic        req_stall,
    input  req_t        req,
    output logic        rsp_valid,
    input  logic        rsp_stall,
    output rsp_t        rsp,
    input  logic        cfg_wen,
    input  logic        cfg_index,
    input  logic [16:0] cfg_data
);

    localparam int CW = $clog2(MAX_ROWS + 1);
    localparam int IW = $clog2(MAX_ROWS);

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_SCAN   = 3'd1;
    localparam logic [2:0] S_DECIDE = 3'd2;
    localparam logic [2:0] S_GROW   = 3'd3;
    localparam logic [2:0] S_REFUSE = 3'd4;

    logic [2:0]    state_reg, state_next;
    logic [9:0]    w_reg, w_next;
    logic [9:0]    h_reg, h_next;
    logic [10:0]   nh_reg, nh_next;
    logic [16:0]   side_reg, side_next;
    logic [16:0]   max_side_reg, max_side_next;
    logic [CW-1:0] count_reg, count_next;
    logic [16:0]   top_reg, top_next;
    logic          launch_reg, launch_next;
    chain_t        best_reg, best_next;
    logic [IW-1:0] best_idx_reg, best_idx_next;
    rsp_t          rsp_reg, rsp_next;
    logic          rsp_valid_reg, rsp_valid_next;

    bcast_t        bcast;
    wr_t           wr;
    logic [IW-1:0] wr_idx;
    chain_t        chain [MAX_ROWS+1];
    logic [IW-1:0] idx_chain [MAX_ROWS+1];
    logic          req_accept;
    logic          finish_ok;
    logic [17:0]   need;
    logic [17:0]   doubled;

    assign bcast = '{w: w_reg, h: h_reg, side: side_reg};

    assign chain[0]     = '{valid: launch_reg, default: '0};
    assign idx_chain[0] = '0;

    for (genvar i = 0; i < MAX_ROWS; i++)
    begin : g_cell
        asa_cell #(
            .MAX_ROWS (MAX_ROWS),
            .IDX      (i)
        ) u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .bcast     (bcast),
            .row_count (count_reg),
            .wr        (wr),
            .wr_idx    (wr_idx),
            .chain_in  (chain[i]),
            .idx_in    (idx_chain[i]),
            .chain_out (chain[i+1]),
            .idx_out   (idx_chain[i+1])
        );
    end

    assign req_stall  = (state_reg != S_IDLE);
    assign req_accept = req_valid && !req_stall;
    assign finish_ok  = !rsp_valid_reg || !rsp_stall;
    assign need       = 18'(top_reg) + 18'(nh_reg);
    assign doubled    = {side_reg, 1'b0};

    always_comb
    begin
        state_next     = state_reg;
        w_next         = w_reg;
        h_next         = h_reg;
        nh_next        = nh_reg;
        side_next      = side_reg;
        max_side_next  = max_side_reg;
        count_next     = count_reg;
        top_next       = top_reg;
        launch_next    = 1'b0;
        best_next      = best_reg;
        best_idx_next  = best_idx_reg;
        rsp_next       = rsp_reg;
        rsp_valid_next = rsp_valid_reg && rsp_stall;
        wr             = '0;
        wr_idx         = best_idx_reg;

        unique case (state_reg)
            S_IDLE:
            begin
                if (req_accept)
                begin
                    w_next  = req.rect_width;
                    h_next  = req.rect_height;
                    nh_next = new_row_height(req.rect_height);
                    if (17'(req.rect_width) > side_reg)
                    begin
                        state_next = S_REFUSE;
                    end
                    else
                    begin
                        launch_next = 1'b1;
                        state_next  = S_SCAN;
                    end
                end
            end
            S_SCAN:
            begin
                if (chain[MAX_ROWS].valid)
                begin
                    best_next     = chain[MAX_ROWS];
                    best_idx_next = idx_chain[MAX_ROWS];
                    state_next    = S_DECIDE;
                end
            end
            S_DECIDE:
            begin
                if (best_reg.found)
                begin
                    if (finish_ok)
                    begin
                        wr.en              = 1'b1;
                        wr.w               = w_reg;
                        rsp_next.pos_x      = best_reg.fill[15:0];
                        rsp_next.pos_y      = best_reg.offset;
                        rsp_next.granted    = 1'b1;
                        rsp_next.atlas_side = side_reg;
                        rsp_next.opened_row = 1'b0;
                        rsp_valid_next      = 1'b1;
                        state_next          = S_IDLE;
                    end
                end
                else if (count_reg == CW'(MAX_ROWS))
                begin
                    state_next = S_REFUSE;
                end
                else
                begin
                    state_next = S_GROW;
                end
            end
            S_GROW:
            begin
                if (need >= 18'(side_reg))
                begin
                    if ((doubled > {1'b0, max_side_reg}) || (doubled > SIDE_LIMIT))
                    begin
                        state_next = S_REFUSE;
                    end
                    else
                    begin
                        side_next = doubled[16:0];
                    end
                end
                else if (finish_ok)
                begin
                    wr.en     = 1'b1;
                    wr.open   = 1'b1;
                    wr.offset = top_reg[15:0];
                    wr.size   = nh_reg;
                    wr.w      = w_reg;
                    wr_idx    = count_reg[IW-1:0];
                    count_next = count_reg + CW'(1);
                    top_next   = need[16:0];
                    rsp_next.pos_x      = '0;
                    rsp_next.pos_y      = top_reg[15:0];
                    rsp_next.granted    = 1'b1;
                    rsp_next.atlas_side = side_reg;
                    rsp_next.opened_row = 1'b1;
                    rsp_valid_next      = 1'b1;
                    state_next          = S_IDLE;
                end
            end
            S_REFUSE:
            begin
                if (finish_ok)
                begin
                    rsp_next.pos_x      = '0;
                    rsp_next.pos_y      = '0;
                    rsp_next.granted    = 1'b0;
                    rsp_next.atlas_side = side_reg;
                    rsp_next.opened_row = 1'b0;
                    rsp_valid_next      = 1'b1;
                    state_next          = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        if (cfg_wen)
        begin
            unique case (cfg_index)
                CFG_INITIAL_SIDE:
                begin
                    if (count_reg == '0)
                    begin
                        side_next = limit_side(cfg_data);
                    end
                end
                CFG_MAX_SIDE:
                begin
                    max_side_next = cfg_data;
                end
                default:
                begin
                    max_side_next = max_side_reg;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            side_reg      <= limit_side(RESET_SIDE);
            max_side_reg  <= RESET_MAX_SIDE;
            count_reg     <= '0;
            top_reg       <= '0;
            launch_reg    <= 1'b0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            side_reg      <= side_next;
            max_side_reg  <= max_side_next;
            count_reg     <= count_next;
            top_reg       <= top_next;
            launch_reg    <= launch_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        w_reg        <= w_next;
        h_reg        <= h_next;
        nh_reg       <= nh_next;
        best_reg     <= best_next;
        best_idx_reg <= best_idx_next;
        rsp_reg      <= rsp_next;
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

    // The row table never holds more rows than the chain has cells.
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CW'(MAX_ROWS))
        else $error("row count above the number of cells");

    // Once a row exists, the next free line stays inside the atlas.
    a_top_inside: assert property (@(posedge clk) disable iff (!rst_n)
        (count_reg != '0) |-> (top_reg < side_reg))
        else $error("next row top outside the atlas");

    // The atlas never shrinks while a request is being worked on.
    a_side_grows: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != S_IDLE) |=> (side_reg >= $past(side_reg)))
        else $error("atlas side shrank during a request");

    // The search token only leaves the chain while the controller waits for it.
    a_token_scan: assert property (@(posedge clk) disable iff (!rst_n)
        chain[MAX_ROWS].valid |-> (state_reg == S_SCAN))
        else $error("search token arrived outside the scan");

    // A response only appears after a request has been worked on.
    a_rsp_source: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(rsp_valid_reg) |-> ($past(state_reg) != S_IDLE))
        else $error("response raised without a request");

endmodule
